### src/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

    // Frame layout
    localparam int PAYLOAD_LEN = 11;
    localparam int POS_W       = 4;

    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] TRAILER_BYTE = 8'hAA;

    localparam logic [POS_W-1:0] POS_HUNT    = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST   = 4'd1;
    localparam logic [POS_W-1:0] POS_TRAILER = 4'd12;

    // Decode constants
    localparam logic [7:0]         THRESHOLD_RESET = 8'd15;
    localparam logic signed [9:0]  GOAL_OFFSET     = 10'sd180;
    localparam logic signed [11:0] ENEMY_OFFSET    = 12'sd45;
    localparam logic signed [8:0]  COURT_OFFSET    = 9'sd127;
    localparam logic [7:0]         AHEAD_LIMIT     = 8'd90;
    localparam logic [7:0]         NEAR_GOAL_CODE  = 8'd1;

    typedef logic [7:0] byte_t;

    // One complete frame as handed from the parser to the decoder
    typedef struct packed {
        logic [PAYLOAD_LEN-1:0][7:0] payload;
        logic signed [8:0]           heading;
    } frame_t;

    // Fold an angle sum back into -180..180
    function automatic logic signed [8:0] wrap_deg(input logic signed [11:0] a);
        logic signed [11:0] r;
        begin
            r = a;
            if (r > 12'sd540)
                r = r - 12'sd720;
            else if (r > 12'sd180)
                r = r - 12'sd360;
            else if (r < -12'sd540)
                r = r + 12'sd720;
            else if (r < -12'sd180)
                r = r + 12'sd360;
            return r[8:0];
        end
    endfunction

    // Magnitude of a wrapped angle, 0..180
    function automatic logic [7:0] abs_deg(input logic signed [8:0] a);
        logic signed [8:0] m;
        begin
            m = (a < 9'sd0) ? -a : a;
            return m[7:0];
        end
    endfunction

endpackage

`default_nettype wire

### src/cfd_fifo.sv
`default_nettype none

module cfd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

### src/cfd_front.sv
`default_nettype none

module cfd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    input  wire logic signed [8:0] heading_deg,
    output cfd_pkg::frame_t        frame,
    output logic                   frame_push
);

    logic [cfd_pkg::POS_W-1:0] pos_reg, pos_next;
    cfd_pkg::byte_t            payload_reg [cfd_pkg::PAYLOAD_LEN];
    logic                      in_payload;

    assign in_payload = (pos_reg != cfd_pkg::POS_HUNT) && (pos_reg != cfd_pkg::POS_TRAILER);

    // Walk the frame: hunt header, collect payload, check trailer
    always_comb
    begin
        pos_next   = pos_reg;
        frame_push = 1'b0;
        if (accept)
        begin
            priority if (pos_reg == cfd_pkg::POS_HUNT)
            begin
                if (rx_byte == cfd_pkg::HEADER_BYTE)
                    pos_next = cfd_pkg::POS_FIRST;
            end
            else if (in_payload)
            begin
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                pos_next   = cfd_pkg::POS_HUNT;
                frame_push = (rx_byte == cfd_pkg::TRAILER_BYTE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= cfd_pkg::POS_HUNT;
        else
            pos_reg <= pos_next;
    end

    // Capture payload bytes in slot order
    always_ff @(posedge clk)
    begin
        if (accept && in_payload)
            payload_reg[cfd_pkg::POS_W'(pos_reg - cfd_pkg::POS_FIRST)] <= rx_byte;
    end

    // Hand the frame on with the heading seen at the trailer
    always_comb
    begin
        for (int i = 0; i < cfd_pkg::PAYLOAD_LEN; i++)
            frame.payload[i] = payload_reg[i];
        frame.heading = heading_deg;
    end

endmodule

`default_nettype wire

### src/cfd_back.sv
`default_nettype none

module cfd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         threshold,
    input  wire cfd_pkg::frame_t    head,
    input  wire logic               head_valid,
    output logic                    head_pop,
    output logic signed [15:0]      ball_direction,
    output logic [7:0]              ball_distance,
    output logic signed [9:0]       front_goal_dir,
    output logic [7:0]              front_goal_size,
    output logic signed [9:0]       rear_goal_dir,
    output logic [7:0]              rear_goal_size,
    output logic signed [8:0]       enemy_direction,
    output logic signed [8:0]       court_x,
    output logic signed [8:0]       court_y,
    output logic                    goal_front_flag,
    output logic                    front_is_yellow,
    output logic                    empty,
    input  wire logic               pop
);

    // Stage A: per-frame arithmetic
    logic                a_valid_reg, a_valid_next;
    logic signed [15:0]  a_ball_reg;
    logic [7:0]          a_dist_reg;
    logic signed [9:0]   a_ydir_reg, a_bdir_reg;
    logic [7:0]          a_ysize_reg, a_bsize_reg;
    logic [7:0]          a_ya_reg, a_ba_reg;
    logic signed [8:0]   a_enemy_reg;
    logic signed [8:0]   a_cx_reg, a_cy_reg;
    logic                a_near_reg;

    // Stage B: state update and result register
    logic                b_valid_reg, b_valid_next;
    logic signed [15:0]  b_ball_reg;
    logic [7:0]          b_dist_reg;
    logic signed [9:0]   b_fdir_reg, b_rdir_reg;
    logic [7:0]          b_fsize_reg, b_rsize_reg;
    logic signed [8:0]   b_enemy_reg;
    logic signed [8:0]   b_cx_reg, b_cy_reg;
    logic [8:0]          count_reg, count_next;
    logic                flag_reg, flag_next;
    logic                yellow_reg, yellow_next;

    logic                a_load;
    logic                b_load;
    logic signed [9:0]   ydir_c, bdir_c;
    logic signed [11:0]  ysum_c, bsum_c, esum_c;
    logic signed [8:0]   enemy_c;

    assign b_load   = a_valid_reg && (!b_valid_reg || pop);
    assign a_load   = head_valid && (!a_valid_reg || b_load);
    assign head_pop = a_load;

    // Goal directions and heading-relative sums
    assign ydir_c = $signed({1'b0, head.payload[3], 1'b0}) - cfd_pkg::GOAL_OFFSET;
    assign bdir_c = $signed({1'b0, head.payload[5], 1'b0}) - cfd_pkg::GOAL_OFFSET;
    assign ysum_c = 12'(ydir_c) + 12'(head.heading);
    assign bsum_c = 12'(bdir_c) + 12'(head.heading);
    assign esum_c = $signed({4'b0, head.payload[7]}) - cfd_pkg::ENEMY_OFFSET
                    + 12'(head.heading);
    assign enemy_c = (head.payload[7] == 8'd0) ? 9'sd0 : cfd_pkg::wrap_deg(esum_c);

    // Advance stage valids
    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_load)
            a_valid_next = 1'b1;
        else if (b_load)
            a_valid_next = 1'b0;
        b_valid_next = b_valid_reg;
        if (b_load)
            b_valid_next = 1'b1;
        else if (pop)
            b_valid_next = 1'b0;
    end

    // Debounce the goal-front flag and pick the goal ahead
    always_comb
    begin
        count_next  = count_reg;
        flag_next   = flag_reg;
        yellow_next = yellow_reg;
        if (b_load)
        begin
            if (a_near_reg)
            begin
                if (count_reg > {1'b0, threshold})
                    flag_next = 1'b1;
                else
                    count_next = count_reg + 9'd1;
            end
            else
            begin
                count_next = '0;
                flag_next  = 1'b0;
            end
            if (a_ya_reg <= cfd_pkg::AHEAD_LIMIT && a_ba_reg >= cfd_pkg::AHEAD_LIMIT)
                yellow_next = 1'b1;
            else if (a_ya_reg >= cfd_pkg::AHEAD_LIMIT && a_ba_reg <= cfd_pkg::AHEAD_LIMIT)
                yellow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            count_reg   <= '0;
            flag_reg    <= 1'b0;
            yellow_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            count_reg   <= count_next;
            flag_reg    <= flag_next;
            yellow_reg  <= yellow_next;
        end
    end

    // Load stage A from the queue head
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_ball_reg  <= {~head.payload[0][7], head.payload[0][6:0], head.payload[1]};
            a_dist_reg  <= head.payload[2];
            a_ydir_reg  <= ydir_c;
            a_bdir_reg  <= bdir_c;
            a_ysize_reg <= head.payload[4];
            a_bsize_reg <= head.payload[6];
            a_ya_reg    <= cfd_pkg::abs_deg(cfd_pkg::wrap_deg(ysum_c));
            a_ba_reg    <= cfd_pkg::abs_deg(cfd_pkg::wrap_deg(bsum_c));
            a_enemy_reg <= enemy_c;
            a_cx_reg    <= $signed({1'b0, head.payload[8]}) - cfd_pkg::COURT_OFFSET;
            a_cy_reg    <= $signed({1'b0, head.payload[9]}) - cfd_pkg::COURT_OFFSET;
            a_near_reg  <= (head.payload[10] == cfd_pkg::NEAR_GOAL_CODE);
        end
    end

    // Load the result register, ordering goals by the new choice
    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_ball_reg  <= a_ball_reg;
            b_dist_reg  <= a_dist_reg;
            b_fdir_reg  <= yellow_next ? a_ydir_reg : a_bdir_reg;
            b_fsize_reg <= yellow_next ? a_ysize_reg : a_bsize_reg;
            b_rdir_reg  <= yellow_next ? a_bdir_reg : a_ydir_reg;
            b_rsize_reg <= yellow_next ? a_bsize_reg : a_ysize_reg;
            b_enemy_reg <= a_enemy_reg;
            b_cx_reg    <= a_cx_reg;
            b_cy_reg    <= a_cy_reg;
        end
    end

    assign ball_direction  = b_ball_reg;
    assign ball_distance   = b_dist_reg;
    assign front_goal_dir  = b_fdir_reg;
    assign front_goal_size = b_fsize_reg;
    assign rear_goal_dir   = b_rdir_reg;
    assign rear_goal_size  = b_rsize_reg;
    assign enemy_direction = b_enemy_reg;
    assign court_x         = b_cx_reg;
    assign court_y         = b_cy_reg;
    assign goal_front_flag = flag_reg;
    assign front_is_yellow = yellow_reg;
    assign empty           = !b_valid_reg;

    // Debounce count stops one past the largest threshold
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 9'd256)
        else $error("debounce count overran");

    // A set flag always follows at least one near-goal frame
    assert property (@(posedge clk) disable iff (!rst_n) flag_reg |-> count_reg != 9'd0)
        else $error("goal-front flag set with zero count");

    // Stage A holds its frame until stage B takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_load |=> a_valid_reg && $stable(a_ydir_reg) && $stable(a_ball_reg))
        else $error("stage A frame lost while stalled");

endmodule

`default_nettype wire

### src/camera_frame_decoder_unit.sv
`default_nettype none

// Camera frame decoder.
// Input channel: one serial byte (rx_byte) with the current heading
// (heading_deg) is taken at each clock edge with push high and full low.
// The parser hunts for header 0xFF, collects 11 payload bytes and checks
// the trailer 0xAA; a good frame is queued for decoding with the heading
// seen on the trailer byte. Bad frames are dropped silently.
// Result channel: while empty is low the decoded frame is on the result
// ports; it is taken at an edge with pop high.
// Throughput: one byte per cycle; the parser never waits on the decoder
// unless the frame queue (FIFO_DEPTH frames) fills.
// A decoded frame passes through the frame queue, the arithmetic stage and
// the result register, in that order.
// If pop stays low, finished frames pile up in the frame queue, and full
// rises only when it holds FIFO_DEPTH frames behind the pending result
// and the frame in the arithmetic stage.
// cfg_we/cfg_wdata set the goal-front debounce threshold (reset 15).
// Reset: parser hunts for a header, queues are empty, debounce count,
// goal-front flag and goal choice (blue ahead) are cleared.

module camera_frame_decoder_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        rx_byte,
    input  wire logic signed [8:0] heading_deg,
    output logic                   empty,
    input  wire logic              pop,
    output logic signed [15:0]     ball_direction,
    output logic [7:0]             ball_distance,
    output logic signed [9:0]      front_goal_dir,
    output logic [7:0]             front_goal_size,
    output logic signed [9:0]      rear_goal_dir,
    output logic [7:0]             rear_goal_size,
    output logic signed [8:0]      enemy_direction,
    output logic signed [8:0]      court_x,
    output logic signed [8:0]      court_y,
    output logic                   goal_front_flag,
    output logic                   front_is_yellow
);

    logic [7:0]      threshold_reg;
    logic            accept;
    logic            frame_push;
    cfd_pkg::frame_t frame_in;
    cfd_pkg::frame_t frame_head;
    logic            fifo_empty;
    logic            head_pop;

    assign accept = push && !full;

    // Hold the debounce threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= cfd_pkg::THRESHOLD_RESET;
        else if (cfg_we)
            threshold_reg <= cfg_wdata;
    end

    cfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .heading_deg (heading_deg),
        .frame       (frame_in),
        .frame_push  (frame_push)
    );

    cfd_fifo #(
        .WIDTH ($bits(cfd_pkg::frame_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (frame_push),
        .wdata (frame_in),
        .full  (full),
        .pop   (head_pop),
        .rdata (frame_head),
        .empty (fifo_empty)
    );

    cfd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .threshold       (threshold_reg),
        .head            (frame_head),
        .head_valid      (!fifo_empty),
        .head_pop        (head_pop),
        .ball_direction  (ball_direction),
        .ball_distance   (ball_distance),
        .front_goal_dir  (front_goal_dir),
        .front_goal_size (front_goal_size),
        .rear_goal_dir   (rear_goal_dir),
        .rear_goal_size  (rear_goal_size),
        .enemy_direction (enemy_direction),
        .court_x         (court_x),
        .court_y         (court_y),
        .goal_front_flag (goal_front_flag),
        .front_is_yellow (front_is_yellow),
        .empty           (empty),
        .pop             (pop)
    );

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_FRAMES = 7;

    typedef struct {
        cfd_pkg::byte_t    data;
        logic signed [8:0] heading;
    } byte_request_t;

    typedef struct {
        logic signed [15:0] ball_angle;
        logic [7:0]         ball_dist;
        logic signed [9:0]  front_dir;
        logic [7:0]         front_size;
        logic signed [9:0]  rear_dir;
        logic [7:0]         rear_size;
        logic signed [8:0]  enemy_angle;
        logic signed [8:0]  pos_x;
        logic signed [8:0]  pos_y;
        logic               near_goal;
        logic               yellow_front;
    } frame_decode_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [7:0]        cfg_wdata   = 8'd0;
    logic              push        = 1'b0;
    logic              full;
    logic [7:0]        rx_byte     = 8'd0;
    logic signed [8:0] heading_deg = 9'sd0;
    logic              empty;
    logic              pop         = 1'b0;
    logic signed [15:0] ball_direction;
    logic [7:0]         ball_distance;
    logic signed [9:0]  front_goal_dir;
    logic [7:0]         front_goal_size;
    logic signed [9:0]  rear_goal_dir;
    logic [7:0]         rear_goal_size;
    logic signed [8:0]  enemy_direction;
    logic signed [8:0]  court_x;
    logic signed [8:0]  court_y;
    logic               goal_front_flag;
    logic               front_is_yellow;

    // Byte requests waiting for the sender, decoded frames waiting for the block
    byte_request_t byte_requests[$];
    frame_decode_t frames_due[$];

    // Decoder shadow state
    logic [3:0]     slot;
    cfd_pkg::byte_t frame_buf [cfd_pkg::PAYLOAD_LEN];
    logic [15:0]    near_count;
    logic           near_flag;
    logic           yellow_sel;
    logic [7:0]     near_limit;

    int burst_left = 1;
    int gap_left   = 0;
    int stall_left = 0;
    int run_left   = 0;
    bit choppy     = 1'b0;

    int fail_count     = 0;
    int idle_cycles    = 0;
    int bytes_taken    = 0;
    int frames_checked = 0;
    int dropped_frames = 0;
    int flag_results   = 0;
    int yellow_results = 0;
    string limits_seen = "15";

    camera_frame_decoder_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .push            (push),
        .full            (full),
        .rx_byte         (rx_byte),
        .heading_deg     (heading_deg),
        .empty           (empty),
        .pop             (pop),
        .ball_direction  (ball_direction),
        .ball_distance   (ball_distance),
        .front_goal_dir  (front_goal_dir),
        .front_goal_size (front_goal_size),
        .rear_goal_dir   (rear_goal_dir),
        .rear_goal_size  (rear_goal_size),
        .enemy_direction (enemy_direction),
        .court_x         (court_x),
        .court_y         (court_y),
        .goal_front_flag (goal_front_flag),
        .front_is_yellow (front_is_yellow)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("frame %0d %s: got %0d, expected %0d",
                                      frames_checked, name, got, want));
        end
    endtask

    function automatic int fold_angle(input int a);
        while (a > 180)
            a -= 360;
        while (a < -180)
            a += 360;
        return a;
    endfunction

    function automatic int magnitude(input int a);
        return (a < 0) ? -a : a;
    endfunction

    // Advance the shadow parser by one byte; queue a decoded frame on a good trailer
    task automatic decode_camera_byte(input cfd_pkg::byte_t data,
                                      input logic signed [8:0] hdg);
        int hd;
        int word;
        int ydir;
        int bdir;
        int ya;
        int ba;
        int b7;
        int bx;
        int by;
        frame_decode_t res;
        hd = int'(hdg);
        if (slot == cfd_pkg::POS_HUNT)
        begin
            if (data == cfd_pkg::HEADER_BYTE)
                slot = cfd_pkg::POS_FIRST;
            return;
        end
        if (slot != cfd_pkg::POS_TRAILER)
        begin
            frame_buf[slot - cfd_pkg::POS_FIRST] = data;
            slot = slot + 1'b1;
            return;
        end
        slot = cfd_pkg::POS_HUNT;
        if (data != cfd_pkg::TRAILER_BYTE)
        begin
            dropped_frames++;
            return;
        end

        word = int'({frame_buf[0], frame_buf[1]});
        ydir = int'(frame_buf[3]);
        ydir = 2 * ydir - 180;
        bdir = int'(frame_buf[5]);
        bdir = 2 * bdir - 180;

        // Debounce the goal-front indication
        if (frame_buf[10] == cfd_pkg::NEAR_GOAL_CODE)
        begin
            if (near_count > near_limit)
                near_flag = 1'b1;
            else
                near_count = near_count + 1'b1;
        end
        else
        begin
            near_count = '0;
            near_flag  = 1'b0;
        end

        // Pick the goal ahead; hold the old choice when undecided
        ya = magnitude(fold_angle(ydir + hd));
        ba = magnitude(fold_angle(bdir + hd));
        if (ya <= 90 && ba >= 90)
            yellow_sel = 1'b1;
        else if (ya >= 90 && ba <= 90)
            yellow_sel = 1'b0;

        res.ball_angle = 16'(word - 32768);
        res.ball_dist  = frame_buf[2];
        if (yellow_sel)
        begin
            res.front_dir  = 10'(ydir);
            res.front_size = frame_buf[4];
            res.rear_dir   = 10'(bdir);
            res.rear_size  = frame_buf[6];
        end
        else
        begin
            res.front_dir  = 10'(bdir);
            res.front_size = frame_buf[6];
            res.rear_dir   = 10'(ydir);
            res.rear_size  = frame_buf[4];
        end
        b7 = int'(frame_buf[7]);
        res.enemy_angle = 9'((b7 == 0) ? 0 : fold_angle(b7 - 45 + hd));
        bx = int'(frame_buf[8]);
        by = int'(frame_buf[9]);
        res.pos_x        = 9'(bx - 127);
        res.pos_y        = 9'(by - 127);
        res.near_goal    = near_flag;
        res.yellow_front = yellow_sel;
        frames_due.push_back(res);
    endtask

    function automatic void queue_byte(input cfd_pkg::byte_t data,
                                       input logic signed [8:0] hdg);
        byte_request_t req;
        req.data    = data;
        req.heading = hdg;
        byte_requests.push_back(req);
    endfunction

    // Mostly legal headings, sometimes the full 9-bit range
    function automatic logic signed [8:0] random_heading();
        if ($urandom_range(0, 6) == 0)
            return 9'($urandom);
        return 9'($urandom_range(0, 360) - 180);
    endfunction

    // Hold off until every request is taken and every frame has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_requests.size() != 0 || push);
        while (frames_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else if (!(push && full))
        begin
            if (push)
                void'(byte_requests.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (byte_requests.size() > 0)
            begin
                push        <= 1'b1;
                rx_byte     <= byte_requests[0].data;
                heading_deg <= byte_requests[0].heading;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                             : $urandom_range(0, 2);
                end
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: runs of steady or choppy pops, each after an optional stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop        <= 1'b0;
            stall_left = 0;
            run_left   = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left--;
            pop <= choppy ? 1'($urandom_range(0, 1)) : 1'b1;
        end
        else
        begin
            run_left   = $urandom_range(1, 60);
            choppy     = ($urandom_range(0, 2) == 0);
            stall_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 30) : 0;
            pop <= (stall_left == 0);
        end
    end

    // Monitor: track config and input requests, check each result request
    always @(posedge clk or negedge rst_n)
    begin : monitor
        frame_decode_t want;
        if (!rst_n)
        begin
            slot       = cfd_pkg::POS_HUNT;
            foreach (frame_buf[i])
                frame_buf[i] = '0;
            near_count = '0;
            near_flag  = 1'b0;
            yellow_sel = 1'b0;
            near_limit = cfd_pkg::THRESHOLD_RESET;
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (cfg_we)
                near_limit = cfg_wdata;
            if (push && !full)
            begin
                idle_cycles = 0;
                bytes_taken++;
                decode_camera_byte(rx_byte, heading_deg);
            end
            if (pop && !empty)
            begin
                idle_cycles = 0;
                if (frames_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected frame, ball_direction %0d",
                                              ball_direction));
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("ball_direction", 32'(ball_direction),
                                32'(want.ball_angle));
                    check_field("ball_distance", 32'(ball_distance),
                                32'(want.ball_dist));
                    check_field("front_goal_dir", 32'(front_goal_dir),
                                32'(want.front_dir));
                    check_field("front_goal_size", 32'(front_goal_size),
                                32'(want.front_size));
                    check_field("rear_goal_dir", 32'(rear_goal_dir),
                                32'(want.rear_dir));
                    check_field("rear_goal_size", 32'(rear_goal_size),
                                32'(want.rear_size));
                    check_field("enemy_direction", 32'(enemy_direction),
                                32'(want.enemy_angle));
                    check_field("court_x", 32'(court_x), 32'(want.pos_x));
                    check_field("court_y", 32'(court_y), 32'(want.pos_y));
                    check_field("goal_front_flag", 32'(goal_front_flag),
                                32'(want.near_goal));
                    check_field("front_is_yellow", 32'(front_is_yellow),
                                32'(want.yellow_front));
                    frames_checked++;
                    if (want.near_goal)
                        flag_results++;
                    if (want.yellow_front)
                        yellow_results++;
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: nothing accepted for %0d cycles, %0d frames still due",
                         STALL_LIMIT, frames_due.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        int             limit;
        int             near_pct;
        int             good;
        int             pick;
        cfd_pkg::byte_t v;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Noise while hunting, then an all-zero frame with heading -256
        queue_byte(8'h00, 9'sd0);
        queue_byte(cfd_pkg::HEADER_BYTE, 9'sd0);
        repeat (cfd_pkg::PAYLOAD_LEN) queue_byte(8'h00, random_heading());
        queue_byte(cfd_pkg::TRAILER_BYTE, 9'h100);
        // All-ones payload with heading 255; header value in the trailer slot is dropped
        queue_byte(cfd_pkg::HEADER_BYTE, 9'h0FF);
        repeat (cfd_pkg::PAYLOAD_LEN) queue_byte(8'hFF, 9'h0FF);
        queue_byte(cfd_pkg::HEADER_BYTE, 9'h0FF);
        queue_byte(8'h5A, 9'h0FF);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       limit = 0;
                1:       limit = 255;
                2:       limit = $urandom_range(1, 5);
                default: limit = $urandom_range(0, 255);
            endcase
            near_pct = (ph == 2) ? 90 : 70;
            limits_seen = {limits_seen, $sformatf(" %0d", limit)};

            // Write the debounce threshold while idle
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= 8'(limit);
            @(posedge clk);
            cfg_we    <= 1'b0;

            good = 0;
            while (good < PHASE_FRAMES)
            begin
                // Drop a few stray bytes while hunting
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                        queue_byte(8'($urandom_range(0, 254)), random_heading());
                end
                queue_byte(cfd_pkg::HEADER_BYTE, random_heading());
                for (int i = 0; i < cfd_pkg::PAYLOAD_LEN; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (i == 10)
                        v = (pick < near_pct) ? cfd_pkg::NEAR_GOAL_CODE
                                              : ($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
                    else if (i == 7 && pick < 20)
                        v = 8'h00;
                    else if (pick < 10)
                        v = 8'h00;
                    else if (pick < 20)
                        v = 8'hFF;
                    else if (pick < 25)
                        v = cfd_pkg::TRAILER_BYTE;
                    else
                        v = 8'($urandom);
                    queue_byte(v, random_heading());
                end
                // Break about one frame in five with a wrong trailer
                pick = $urandom_range(0, 99);
                if (pick < 20)
                begin
                    v = (pick < 7) ? cfd_pkg::HEADER_BYTE : 8'($urandom);
                    if (v == cfd_pkg::TRAILER_BYTE)
                        v = 8'h00;
                end
                else
                begin
                    v = cfd_pkg::TRAILER_BYTE;
                    good++;
                end
                queue_byte(v, random_heading());
            end
            wait_idle();
        end

        $display("Checked %0d decoded frames from %0d bytes; %0d frames dropped on a bad trailer.",
                 frames_checked, bytes_taken, dropped_frames);
        $display("Debounce thresholds %s; %0d frames with goal-front set, %0d with yellow ahead.",
                 limits_seen, flag_results, yellow_results);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
